[hw/rtl/ltsv_pkg.sv]
package ltsv_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FracW = 16;
  localparam int unsigned QuoW  = DataW + FracW;

  localparam logic signed [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};

  // configuration register indexes
  localparam logic RegRows  = 1'b0;
  localparam logic RegScale = 1'b1;

  localparam logic OpMatrix = 1'b0;
  localparam logic OpColumn = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
    logic                    zdiv;
  } elem_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    ovf;
  } clamp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIAG,
    ST_DCHK,
    ST_DIV,
    ST_ELIM,
    ST_OUT
  } state_e;

  function automatic clamp_t clamp49(input logic signed [QuoW:0] v);
    clamp_t r;
    if (v > QuoW'(MaxVal)) begin
      r.val = MaxVal;
      r.ovf = 1'b1;
    end else if (v < $signed({{(QuoW-DataW+1){1'b1}}, MinVal})) begin
      r.val = MinVal;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DataW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

[hw/rtl/ltsv_cell.sv]
module ltsv_cell
  import ltsv_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  elem_t nxt_i,
  input  logic  ld_i,
  input  elem_t ld_elem_i,
  input  logic  clr_i,
  output elem_t elem_o
);

  elem_t elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    if (shift_i) begin
      elem_d = nxt_i;
    end else if (ld_i) begin
      elem_d = ld_elem_i;
    end else if (clr_i) begin
      elem_d.sat  = 1'b0;
      elem_d.zdiv = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

[hw/rtl/ltsv_div.sv]
module ltsv_div
  import ltsv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DataW-1:0] num_i,
  input  logic signed [DataW-1:0] den_i,
  output logic                    done_o,
  output clamp_t                  res_o
);

  localparam int unsigned CntW = $clog2(QuoW);

  logic            busy_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [QuoW-1:0] quo_q;
  logic [DataW-1:0] rem_q, den_q;
  logic [DataW:0]  rem_sh;
  logic            fits;
  logic [DataW-1:0] num_mag, den_mag;

  assign num_mag = num_i[DataW-1] ? DataW'(-num_i) : DataW'(num_i);
  assign den_mag = den_i[DataW-1] ? DataW'(-den_i) : DataW'(den_i);
  assign rem_sh  = {rem_q, quo_q[QuoW-1]};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(QuoW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= {num_mag, {FracW{1'b0}}};
      rem_q <= '0;
      den_q <= den_mag;
      neg_q <= num_i[DataW-1] ^ den_i[DataW-1];
    end else if (busy_q) begin
      rem_q <= fits ? DataW'(rem_sh - {1'b0, den_q}) : rem_sh[DataW-1:0];
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      res_o = clamp49(-$signed({1'b0, quo_q}));
    end else begin
      res_o = clamp49($signed({1'b0, quo_q}));
    end
  end

  assign done_o = done_q;

endmodule

[hw/rtl/lower_triangular_solve.sv]
// channel  | dir | tdata (low bit up)                       | tuser | tlast
// s_axis   | in  | row, col, value, column_tag              | op    | last
// m_axis   | out | solution, out_row, out_tag, zero_divide, | -     | out_last
//          |     | saturated                                |       |
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i          |       |
// loads are taken while idle. a solve runs one scale lap around the cell ring, then per
// pivot a diagonal read, a division in the serial divider (skipped for a zero element
// or zero diagonal) and an elimination lap (skipped for a zero element and after the
// last pivot), then M results at one per cycle while the output is not stalled. no item
// is taken during a solve; the output register stalls only the emit phase. reset clears
// control state and the configuration registers.
module lower_triangular_solve
  import ltsv_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // row, col, value, column_tag
  input  logic [0:0]  s_axis_tuser,  // op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // solution, out_row, out_tag, zero_divide, saturated
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned RowW  = $clog2(MAX_ROWS);
  localparam int unsigned PosW  = $clog2(MAX_ROWS + 2);
  localparam int unsigned Limit = (MAX_ROWS < 16) ? MAX_ROWS : 16;

  // input fields
  logic [3:0]              in_row, in_col;
  logic signed [DataW-1:0] in_value;
  logic [7:0]              in_tag;
  logic                    in_acc;

  assign in_row   = s_axis_tdata[3:0];
  assign in_col   = s_axis_tdata[7:4];
  assign in_value = s_axis_tdata[39:8];
  assign in_tag   = s_axis_tdata[47:40];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // configuration
  logic [4:0]              rows_q;
  logic signed [DataW-1:0] scale_q;
  logic [7:0]              tag_q;
  logic [4:0]              m_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 5'd16;
      scale_q <= 32'sd65536;
      tag_q   <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == RegRows)  rows_q  <= cfg_data_i[4:0];
      if (cfg_we_i && cfg_idx_i == RegScale) scale_q <= cfg_data_i;
      if (in_acc && s_axis_tuser[0] == OpColumn) tag_q <= in_tag;
    end
  end

  always_comb begin
    if (rows_q == '0) m_w = 5'd1;
    else if (int'(rows_q) > Limit) m_w = 5'(Limit);
    else m_w = rows_q;
  end

  // control
  state_e          state_q, state_d;
  logic [RowW-1:0] k_q, k_d, oi_q, oi_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic signed [DataW-1:0] bk_q, bk_d;
  logic            shift, clr, ld, div_start, out_load, last_pivot;
  logic [RowW-1:0] ld_idx, sel_idx;
  elem_t           ld_elem, sel_elem;

  // matrix store
  logic [DataW-1:0]  mem [2**(2*RowW)];
  logic [DataW-1:0]  rdata_q;
  logic [2*RowW-1:0] rd_addr;
  logic              mem_we;

  assign mem_we = in_acc && s_axis_tuser[0] == OpMatrix
                  && int'(in_row) < MAX_ROWS && int'(in_col) < MAX_ROWS;

  always_comb begin
    if (state_q == ST_DIAG) rd_addr = {k_q, k_q};
    else rd_addr = {pos_q[RowW-1:0], k_q};
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[{RowW'(in_row), RowW'(in_col)}] <= in_value;
    rdata_q <= mem[rd_addr];
  end

  // cell ring: cells, then two unit stages back into the last cell
  elem_t cells [MAX_ROWS];
  elem_t s0_q, s1_q, tail;
  logic  s0_act_q, s1_act_q, s0_scale_q, s1_scale_q, s0_act;
  logic signed [DataW-1:0]   s0_bk_q;
  logic signed [2*DataW-1:0] prod_q;
  logic signed [QuoW-1:0]    t_q;
  clamp_t                    upd;

  assign s0_act = int'(pos_q) < int'(m_w)
                  && (state_q == ST_SCALE || int'(pos_q) > int'(k_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_act_q <= 1'b0;
      s1_act_q <= 1'b0;
    end else if (shift) begin
      s0_act_q <= s0_act;
      s1_act_q <= s0_act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      s0_q       <= cells[0];
      s0_scale_q <= state_q == ST_SCALE;
      s0_bk_q    <= bk_q;
      s1_q       <= s0_q;
      s1_scale_q <= s0_scale_q;
      prod_q     <= s0_scale_q ? s0_q.val * scale_q : s0_bk_q * $signed(rdata_q);
    end
  end

  assign t_q = QuoW'(prod_q >>> FracW);

  always_comb begin
    if (s1_scale_q) upd = clamp49({t_q[QuoW-1], t_q});
    else upd = clamp49($signed({{(QuoW-DataW+1){s1_q.val[DataW-1]}}, s1_q.val})
                       - $signed({t_q[QuoW-1], t_q}));
    tail = s1_q;
    if (s1_act_q) begin
      tail.val = upd.val;
      tail.sat = s1_q.sat | upd.ovf;
    end
  end

  for (genvar j = 0; j < MAX_ROWS; j++) begin : g_cell
    elem_t nxt;
    if (j == MAX_ROWS - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = cells[j+1];
    end
    ltsv_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (shift),
      .nxt_i     (nxt),
      .ld_i      (ld && ld_idx == RowW'(j)),
      .ld_elem_i (ld_elem),
      .clr_i     (clr),
      .elem_o    (cells[j])
    );
  end

  assign sel_idx  = (state_q == ST_OUT) ? oi_q : k_q;
  assign sel_elem = cells[sel_idx];

  // divider
  logic   div_done;
  clamp_t div_res;

  ltsv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sel_elem.val),
    .den_i   ($signed(rdata_q)),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // output register
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_last_q;

  assign last_pivot = int'(k_q) == int'(m_w) - 1;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    oi_d      = oi_q;
    pos_d     = pos_q;
    bk_d      = bk_q;
    shift     = 1'b0;
    clr       = 1'b0;
    ld        = 1'b0;
    ld_idx    = k_q;
    ld_elem   = sel_elem;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser[0] == OpColumn) begin
          ld_idx       = RowW'(in_row);
          ld_elem.val  = in_value;
          ld_elem.sat  = 1'b0;
          ld_elem.zdiv = 1'b0;
          ld           = int'(in_row) < MAX_ROWS;
          if (s_axis_tlast) begin
            clr     = 1'b1;
            k_d     = '0;
            pos_d   = '0;
            state_d = ST_SCALE;
          end
        end
      end
      ST_SCALE, ST_ELIM: begin
        shift = 1'b1;
        pos_d = pos_q + 1'b1;
        if (int'(pos_q) == MAX_ROWS + 1) begin
          pos_d   = '0;
          state_d = ST_DIAG;
          if (state_q == ST_ELIM) k_d = k_q + 1'b1;
        end
      end
      ST_DIAG: state_d = ST_DCHK;
      ST_DCHK: begin
        bk_d = sel_elem.val;
        if (sel_elem.val == '0) begin
          // zero element: nothing below changes
          if (last_pivot) begin
            oi_d    = '0;
            state_d = ST_OUT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_DIAG;
          end
        end else if (rdata_q == '0) begin
          ld           = 1'b1;
          ld_elem.val  = sel_elem.val[DataW-1] ? MinVal : MaxVal;
          ld_elem.zdiv = 1'b1;
          bk_d         = ld_elem.val;
          oi_d         = '0;
          state_d      = last_pivot ? ST_OUT : ST_ELIM;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ld          = 1'b1;
          ld_elem.val = div_res.val;
          ld_elem.sat = sel_elem.sat | div_res.ovf;
          bk_d        = div_res.val;
          oi_d        = '0;
          state_d     = last_pivot ? ST_OUT : ST_ELIM;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          oi_d     = oi_q + 1'b1;
          if (int'(oi_q) == int'(m_w) - 1) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      oi_q        <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      oi_q    <= oi_d;
      pos_q   <= pos_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bk_q <= bk_d;
    if (out_load) begin
      out_data_q <= {2'b00, sel_elem.sat, sel_elem.zdiv, tag_q, 4'(oi_q), sel_elem.val};
      out_last_q <= int'(oi_q) == int'(m_w) - 1;
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
